>>> design/srtf_preemptive_scheduler_core_assert.svh
// Assertion macros shared by the SRTF scheduler checker.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_CORE_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/srtf_pkg.sv
// Types and constants of the SRTF scheduler: request, result and job table entry.
// No dependencies; used by the core, the RAM users and the checker.
package srtf_pkg;

  localparam int TIME_BITS = 16;
  localparam int SLOT_BITS = 4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  typedef struct packed {
    logic                 req_type;
    logic [SLOT_BITS-1:0] slot;
    time_t                arrival_time;
    time_t                burst_length;
  } request_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] ran_slot;
    logic                 idle;
    logic                 new_segment;
    time_t                time_now;
    logic                 job_done;
    time_t                turnaround;
    time_t                wait_time;
  } result_t;

  typedef struct packed {
    time_t arrival;
    time_t burst;
    time_t remaining;
  } job_entry_t;

endpackage

>>> design/srtf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srtf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/srtf_preemptive_scheduler_core.sv
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Depends on srtf_pkg (types, constants) and srtf_ram (job table storage).
//
//   Channel   Signals                    Direction  Transfer
//   request   start, busy, request       in         start high while busy low
//   result    done, result               out        done high for one cycle
//
// A load transfer's acknowledgement shows on the cycle after it, and busy never
// rises. A tick transfer holds busy high while the job table is read one slot
// per cycle through its single read port and one comparator keeps the best
// candidate; a drain state then takes the last read, an execute state runs the
// chosen job and a report state forms the report. The report shows in the first
// cycle in which busy is low, and a new request can be taken in that same cycle.
// Synchronous reset clears the valid and done flags, the clock and the
// sequencer. The receiver cannot stall; each result is shown for one cycle.
module srtf_preemptive_scheduler_core #(
  parameter int MAX_JOBS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  srtf_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output srtf_pkg::result_t  result
);

  import srtf_pkg::*;

  localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int ENTRY_W = $bits(job_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]          state;
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_ok;
  logic [MAX_JOBS-1:0] valid_flags;
  logic [MAX_JOBS-1:0] done_flags;
  time_t               clock_time;
  logic                cur_valid;
  logic [IDX_W-1:0]    cur_job;
  logic                found;
  logic [IDX_W-1:0]    best_idx;
  job_entry_t          best_entry;
  time_t               tat;
  logic                job_done_r;
  logic                new_seg_r;

  logic             accept;
  logic             is_load;
  logic             load_ok;
  logic [IDX_W-1:0] slot_addr;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  job_entry_t       ram_wdata;
  job_entry_t       rd_entry;
  logic             better;
  time_t            clk_next;
  time_t            rem_dec;
  time_t            wait_calc;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign is_load   = (request.req_type == REQ_LOAD);
  assign load_ok   = (int'(request.slot) < MAX_JOBS);
  assign slot_addr = IDX_W'(request.slot);

  // The clock stops at its maximum value rather than wrapping.
  assign clk_next = (clock_time == TIME_MAX) ? clock_time : clock_time + 1'b1;
  assign rem_dec  = best_entry.remaining - 1'b1;

  // Shared comparator: the slot read last cycle replaces the best candidate
  // only on a strictly smaller remaining time, so the lowest slot wins ties.
  assign better = rd_ok && (rd_entry.arrival <= clock_time) &&
                  (!found || (rd_entry.remaining < best_entry.remaining));

  // Wait time is turnaround minus burst, floored at zero once the clock saturates.
  assign wait_calc = (tat >= best_entry.burst) ? (tat - best_entry.burst) : '0;

  // The table is written either by a load or by the executed job's countdown.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    ram_wdata = '{arrival: request.arrival_time, burst: request.burst_length,
                  remaining: request.burst_length};
    if (accept && is_load && load_ok) begin
      ram_we = 1'b1;
    end else if (state == ST_EXEC && found) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = '{arrival: best_entry.arrival, burst: best_entry.burst,
                    remaining: rem_dec};
    end
  end

  srtf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_JOBS)
  ) u_job_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx),
    .rdata(rd_entry)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_idx    <= '0;
      rd_ok       <= 1'b0;
      valid_flags <= '0;
      done_flags  <= '0;
      clock_time  <= '0;
      cur_valid   <= 1'b0;
      cur_job     <= '0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (load_ok) begin
                valid_flags[slot_addr] <= 1'b1;
                done_flags[slot_addr]  <= (request.burst_length == '0);
              end
              done <= 1'b1;
            end else begin
              scan_idx <= '0;
              rd_ok    <= 1'b0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Flags are captured with the read so they line up with the data.
          rd_ok <= valid_flags[scan_idx] && !done_flags[scan_idx];
          if (better) begin
            found <= 1'b1;
          end
          if (scan_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (better) begin
            found <= 1'b1;
          end
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          clock_time <= clk_next;
          if (found) begin
            cur_valid <= 1'b1;
            cur_job   <= best_idx;
            if (rem_dec == '0) begin
              done_flags[best_idx] <= 1'b1;
            end
          end
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rd_idx <= scan_idx;
    end
    if ((state == ST_SCAN || state == ST_DRAIN) && better) begin
      best_idx   <= rd_idx;
      best_entry <= rd_entry;
    end
    if (state == ST_EXEC) begin
      new_seg_r  <= found && (!cur_valid || (cur_job != best_idx));
      job_done_r <= found && (rem_dec == '0);
      tat        <= clk_next - best_entry.arrival;
    end
    if (state == ST_IDLE && accept && is_load) begin
      result <= '{ran_slot: '0, idle: 1'b1, new_segment: 1'b0,
                  time_now: clock_time, job_done: 1'b0,
                  turnaround: '0, wait_time: '0};
    end else if (state == ST_REPORT) begin
      result.ran_slot    <= found ? SLOT_BITS'(best_idx) : '0;
      result.idle        <= !found;
      result.new_segment <= new_seg_r;
      result.time_now    <= clock_time;
      result.job_done    <= job_done_r;
      result.turnaround  <= job_done_r ? tat : '0;
      result.wait_time   <= job_done_r ? wait_calc : '0;
    end
  end

endmodule

>>> design/srtf_checker.sv
// Port-level checks on the SRTF scheduler, attached to the top level by bind.
// Depends on srtf_pkg and the macros in srtf_preemptive_scheduler_core_assert.svh.
`include "srtf_preemptive_scheduler_core_assert.svh"

module srtf_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input srtf_pkg::request_t request,
  input srtf_pkg::result_t  result
);

  import srtf_pkg::*;

  logic load_xfer;
  logic tick_xfer;

  assign load_xfer = start && !busy && (request.req_type == REQ_LOAD);
  assign tick_xfer = start && !busy && (request.req_type == REQ_TICK);

  `SRTF_ASSERT_SAME(a_done_not_busy, done, !busy, "result shown while busy")
  `SRTF_ASSERT_NEXT(a_load_ack, load_xfer, done && result.idle && !busy, "load not acknowledged")
  `SRTF_ASSERT_NEXT(a_tick_busy, tick_xfer, busy && !done, "tick did not occupy the block")
  `SRTF_ASSERT_SAME(a_idle_clean, done && result.idle, !result.job_done && !result.new_segment, "idle result reports a job")

endmodule

bind srtf_preemptive_scheduler_core srtf_checker u_srtf_checker (.*);
